// ===== rtl/chunked_transfer_decoder_top_assert.svh =====
// Assertion macros for the chunked transfer decoder checker.
// Included by the checker file; needs clk_i and rst_ni in scope.
`ifndef CHUNKED_TRANSFER_DECODER_TOP_ASSERT_SVH
`define CHUNKED_TRANSFER_DECODER_TOP_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset
`define CTD_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion on the block clock and reset
`define CTD_ASSERT(label, prop, msg) \
  `CTD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/ctd_pkg.sv =====
// Shared types, constants and the hex digit decoder of the chunked decoder.
// No dependencies; imported by every module of the block.
package ctd_pkg;

  localparam int unsigned ByteW           = 8;
  localparam int unsigned CfgW            = 4;
  localparam int unsigned NibbleW         = 4;
  localparam int unsigned SizeDigitsLimit = 8;
  localparam int unsigned SizeW           = NibbleW * SizeDigitsLimit;
  localparam int unsigned CountW          = 4;

  localparam logic [CfgW-1:0]   MaxDigitsReset = 4'd5;
  localparam logic [CountW-1:0] DigitsMin      = 4'd1;
  localparam logic [CountW-1:0] DigitsMax      = CountW'(SizeDigitsLimit);
  localparam logic [ByteW-1:0]  ChCr           = 8'h0D;
  localparam logic [ByteW-1:0]  ChLf           = 8'h0A;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_BODY  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef enum logic [7:0] {
    PH_SIZE     = 8'b0000_0001,
    PH_SIZE_LF  = 8'b0000_0010,
    PH_DATA     = 8'b0000_0100,
    PH_DATA_CR  = 8'b0000_1000,
    PH_DATA_LF  = 8'b0001_0000,
    PH_FINAL_CR = 8'b0010_0000,
    PH_FINAL_LF = 8'b0100_0000,
    PH_HALT     = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             first;
  } in_word_t;

  // Registered input word handed to the decode stage
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } in_stage_t;

  typedef struct packed {
    logic               valid;
    logic [NibbleW-1:0] value;
  } hex_t;

  // Decode one ASCII hex digit (0-9, a-f, A-F)
  function automatic hex_t hex_decode(logic [ByteW-1:0] c);
    hex_t h;
    h.valid = 1'b0;
    h.value = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.value = NibbleW'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.valid = 1'b1;
      h.value = NibbleW'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.valid = 1'b1;
      h.value = NibbleW'(c - 8'h37);
    end
    return h;
  endfunction

endpackage

// ===== rtl/ctd_in_stage.sv =====
// Input register of the chunked decoder: takes one word from the stream port.
// Depends on ctd_pkg.
module ctd_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  ctd_pkg::in_word_t     s_word_i,
  output ctd_pkg::in_stage_t    stage_o,
  input  logic                  stage_ready_i
);
  import ctd_pkg::*;

  logic     full_q, full_d;
  in_word_t word_q;
  logic     load;

  // Accept when empty or when the held word moves on this cycle
  assign s_ready_o = !full_q || stage_ready_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    full_d = full_q;
    if (load) begin
      full_d = 1'b1;
    end else if (stage_ready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // Hold the payload until it is replaced
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= s_word_i;
    end
  end

  assign stage_o.valid = full_q;
  assign stage_o.word  = word_q;

endmodule

// ===== rtl/ctd_core.sv =====
// Decode stage of the chunked decoder: framing state, size parse and the
// result register. Depends on ctd_pkg.
module ctd_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ctd_pkg::CfgW-1:0]    cfg_wdata_i,
  input  ctd_pkg::in_stage_t          stage_i,
  output logic                        stage_ready_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output ctd_pkg::kind_e              m_kind_o,
  output logic [ctd_pkg::ByteW-1:0]   m_body_byte_o
);
  import ctd_pkg::*;

  logic [CfgW-1:0]   max_digits_q;
  phase_e            phase_q, phase_d, phase_c;
  logic [SizeW-1:0]  acc_q, acc_d, acc_c;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_c;
  logic [SizeW-1:0]  rem_q, rem_d, rem_c;
  logic [CountW-1:0] limit;
  hex_t              hex;
  logic [ByteW-1:0]  c;
  kind_e             kind;
  logic [ByteW-1:0]  body;
  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [ByteW-1:0]  out_body_q;
  logic              out_free;
  logic              consume;

  assign out_free      = !out_valid_q || m_ready_i;
  assign consume       = stage_i.valid && out_free;
  assign stage_ready_o = out_free;

  // Clamp the digit limit to the supported range
  always_comb begin
    limit = CountW'(max_digits_q);
    if (max_digits_q == '0) begin
      limit = DigitsMin;
    end else if (CountW'(max_digits_q) > DigitsMax) begin
      limit = DigitsMax;
    end
  end

  assign c   = stage_i.word.in_byte;
  assign hex = hex_decode(c);

  // Start a new message: clear state before the byte is used
  always_comb begin
    if (stage_i.word.first) begin
      phase_c = PH_SIZE;
      acc_c   = '0;
      cnt_c   = '0;
      rem_c   = '0;
    end else begin
      phase_c = phase_q;
      acc_c   = acc_q;
      cnt_c   = cnt_q;
      rem_c   = rem_q;
    end
  end

  // One framing step per byte
  always_comb begin
    phase_d = phase_c;
    acc_d   = acc_c;
    cnt_d   = cnt_c;
    rem_d   = rem_c;
    kind    = KIND_FRAME;
    body    = '0;
    case (phase_c)
      PH_SIZE: begin
        if (hex.valid) begin
          if (cnt_c >= limit) begin
            kind    = KIND_ERR;
            phase_d = PH_HALT;
          end else begin
            acc_d = {acc_c[SizeW-NibbleW-1:0], hex.value};
            cnt_d = cnt_c + CountW'(1);
          end
        end else if (c == ChCr && cnt_c != '0) begin
          phase_d = PH_SIZE_LF;
        end else begin
          kind    = KIND_ERR;
          phase_d = PH_HALT;
        end
      end
      PH_SIZE_LF: begin
        if (c != ChLf) begin
          kind    = KIND_ERR;
          phase_d = PH_HALT;
        end else if (acc_c == '0) begin
          phase_d = PH_FINAL_CR;
        end else begin
          rem_d   = acc_c;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        kind  = KIND_BODY;
        body  = c;
        rem_d = rem_c - SizeW'(1);
        if (rem_c == SizeW'(1)) begin
          phase_d = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (c == ChCr) begin
          phase_d = PH_DATA_LF;
        end else begin
          kind    = KIND_ERR;
          phase_d = PH_HALT;
        end
      end
      PH_DATA_LF: begin
        if (c == ChLf) begin
          phase_d = PH_SIZE;
          acc_d   = '0;
          cnt_d   = '0;
        end else begin
          kind    = KIND_ERR;
          phase_d = PH_HALT;
        end
      end
      PH_FINAL_CR: begin
        if (c == ChCr) begin
          phase_d = PH_FINAL_LF;
        end else begin
          kind    = KIND_ERR;
          phase_d = PH_HALT;
        end
      end
      PH_FINAL_LF: begin
        phase_d = PH_HALT;
        kind    = (c == ChLf) ? KIND_DONE : KIND_ERR;
      end
      default: begin
        kind    = KIND_ERR;
        phase_d = PH_HALT;
      end
    endcase
  end

  // Advance state and the config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_digits_q <= MaxDigitsReset;
      phase_q      <= PH_SIZE;
      acc_q        <= '0;
      cnt_q        <= '0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_digits_q <= cfg_wdata_i;
      end
      if (consume) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        rem_q   <= rem_d;
      end
      if (consume) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (consume) begin
      out_kind_q <= kind;
      out_body_q <= body;
    end
  end

  assign m_valid_o     = out_valid_q;
  assign m_kind_o      = out_kind_q;
  assign m_body_byte_o = out_body_q;

endmodule

// ===== rtl/chunked_transfer_decoder_top.sv =====
// Chunked transfer body decoder: one raw byte in, one result word out.
// Input register, decode stage with framing state, and result register.
// Usage:
//   s_axis carries one body byte per word; tuser[0] marks the first byte of a
//   new message and clears the framing state before that byte is decoded.
//   m_axis returns exactly one word per input word: tuser holds the kind
//   (framing, body byte, message complete, error), tdata the body byte
//   (zero unless the kind is body byte).
//   cfg_we_i writes the size digit limit (reset 5; 0 acts as 1, above 8 as 8);
//   write it only while no word is in flight.
// Timing:
//   An accepted word passes the input register, then the result register.
//   Throughput is one word per cycle while m_axis_tready is high, set by the
//   single decode stage updating the phase, size and remaining byte counters.
// Reset and stall:
//   Reset empties both registers and returns to reading a size line.
//   When m_axis_tready is low the result holds, the input register fills, and
//   s_axis_tready then drops until the result is taken.
//   After completion or an error every byte yields an error until a byte
//   marked first arrives.
module chunked_transfer_decoder_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ctd_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]                s_axis_tuser,   // [0] first
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] body_byte
  output logic [1:0]                m_axis_tuser    // [1:0] kind
);
  import ctd_pkg::*;

  in_word_t  s_word;
  in_stage_t stage;
  logic      stage_ready;
  kind_e     m_kind;

  assign s_word.in_byte = s_axis_tdata;
  assign s_word.first   = s_axis_tuser[0];

  ctd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_word_i     (s_word),
    .stage_o      (stage),
    .stage_ready_i(stage_ready)
  );

  ctd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .stage_i      (stage),
    .stage_ready_o(stage_ready),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_kind_o     (m_kind),
    .m_body_byte_o(m_axis_tdata)
  );

  assign m_axis_tuser = m_kind;

endmodule

// ===== rtl/ctd_checker.sv =====
// Port-level checks for the chunked transfer decoder, bound to the top level.
// Depends on ctd_pkg and chunked_transfer_decoder_top_assert.svh.
`include "chunked_transfer_decoder_top_assert.svh"

module ctd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);
  import ctd_pkg::*;

  // A stalled result holds its word
  `CTD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // Only body words carry a data byte
  `CTD_ASSERT(a_body_zero, m_axis_tvalid && m_axis_tuser != KIND_BODY |-> m_axis_tdata == '0, "non-body word has data")

  // A new result follows an earlier accepted input word
  `CTD_ASSERT(a_out_cause, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without input")

  // Input is never stalled while the result register is empty
  `CTD_ASSERT(a_no_idle_stall, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

endmodule

bind chunked_transfer_decoder_top ctd_checker u_ctd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ===== tb/chunked_transfer_decoder_top_test.sv =====
// Self-checking testbench for chunked_transfer_decoder_top: random chunked messages,
// corrupted framing and stream stalls, checked against an in-bench byte decoder.
// Depends on ctd_pkg and the RTL of the block only.
module chunked_transfer_decoder_top_test;
  import ctd_pkg::*;

  typedef struct {
    kind_e            kind;
    logic [ByteW-1:0] body;
  } result_t;

  typedef struct {
    logic [ByteW-1:0] b;
    logic             f;
  } in_item_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_e;

  // Byte-level decoder model and result queue
  class chunk_scoreboard;
    logic [CfgW-1:0]   max_digits;
    phase_e            ph;
    logic [SizeW-1:0]  size_acc;
    logic [CountW-1:0] ndigits;
    logic [SizeW-1:0]  remaining;
    result_t           expected_q[$];
    int errors, bytes_seen, body_seen, done_seen, err_seen;

    function new();
      max_digits = MaxDigitsReset;
      clear();
    endfunction

    function void clear();
      ph        = PH_SIZE;
      size_acc  = '0;
      ndigits   = '0;
      remaining = '0;
    endfunction

    function void set_limit(logic [CfgW-1:0] v);
      max_digits = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Clamp the register into 1..SizeDigitsLimit
    function int limit();
      if (max_digits == 0) return 1;
      if (max_digits > SizeDigitsLimit) return SizeDigitsLimit;
      return max_digits;
    endfunction

    function int hex_val(logic [ByteW-1:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function kind_e halt_err();
      ph = PH_HALT;
      return KIND_ERR;
    endfunction

    // Advance the model by one accepted byte and queue its result
    function void note_byte(logic [ByteW-1:0] c, logic first);
      kind_e            k;
      logic [ByteW-1:0] body;
      int               h;
      k    = KIND_FRAME;
      body = '0;
      bytes_seen++;
      if (first) clear();
      case (ph)
        PH_SIZE: begin
          h = hex_val(c);
          if (h >= 0) begin
            if (ndigits >= limit()) k = halt_err();
            else begin
              size_acc = {size_acc[SizeW-NibbleW-1:0], NibbleW'(h)};
              ndigits  = ndigits + 1'b1;
            end
          end else if (c == ChCr && ndigits != 0) ph = PH_SIZE_LF;
          else k = halt_err();
        end
        PH_SIZE_LF: begin
          if (c != ChLf) k = halt_err();
          else if (size_acc == 0) ph = PH_FINAL_CR;
          else begin
            remaining = size_acc;
            ph        = PH_DATA;
          end
        end
        PH_DATA: begin
          k         = KIND_BODY;
          body      = c;
          remaining = remaining - 1'b1;
          if (remaining == 0) ph = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (c == ChCr) ph = PH_DATA_LF;
          else k = halt_err();
        end
        PH_DATA_LF: begin
          if (c == ChLf) begin
            ph       = PH_SIZE;
            size_acc = '0;
            ndigits  = '0;
          end else k = halt_err();
        end
        PH_FINAL_CR: begin
          if (c == ChCr) ph = PH_FINAL_LF;
          else k = halt_err();
        end
        PH_FINAL_LF: begin
          if (c == ChLf) begin
            k  = KIND_DONE;
            ph = PH_HALT;
          end else k = halt_err();
        end
        default: k = halt_err();
      endcase
      case (k)
        KIND_BODY: body_seen++;
        KIND_DONE: done_seen++;
        KIND_ERR:  err_seen++;
        default: ;
      endcase
      expected_q.push_back('{k, body});
    endfunction

    // Compare one output word with the oldest expectation
    function void check_result(logic [1:0] kind, logic [ByteW-1:0] data);
      result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, kind %0d body %02h", $time, kind, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: kind mismatch, expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (data !== e.body) begin
        $display("%0t: body mismatch, expected %02h actual %02h", $time, e.body, data);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CfgW-1:0]  cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic [0:0]       s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  chunk_scoreboard  sb = new();
  in_item_t         stim_q[$];
  logic [ByteW-1:0] msg_q[$];
  int               burst_left = 1;
  int               rx_left = 0;
  rx_mode_e         rx_mode = RX_OPEN;
  int               limits_run = 0;

  chunked_transfer_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stall the result side in changing patterns, including fully open stretches
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default:   m_axis_tready <= ((rx_left / 8) % 3 != 0);
    endcase
  end

  // Check every word taken from the result side
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  function automatic logic [ByteW-1:0] hex_char(int v);
    if (v < 10) return ByteW'("0" + v);
    return ByteW'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
  endfunction

  function automatic int clamp_limit(int v);
    if (v == 0) return 1;
    if (v > SizeDigitsLimit) return SizeDigitsLimit;
    return v;
  endfunction

  function automatic int min_digits(logic [SizeW-1:0] v);
    int n;
    n = 1;
    while (n < SizeDigitsLimit && (v >> (NibbleW * n)) != 0) n++;
    return n;
  endfunction

  function automatic void push_size_line(logic [SizeW-1:0] v, int ndig);
    for (int i = ndig - 1; i >= 0; i--) msg_q.push_back(hex_char((v >> (NibbleW * i)) & 'hF));
    msg_q.push_back(ChCr);
    msg_q.push_back(ChLf);
  endfunction

  // Pick a byte likely to break framing, or any byte at all
  function automatic logic [ByteW-1:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return ChCr;
      1: return ChLf;
      2: return hex_char($urandom_range(0, 15));
      3: return "g";
      4: return ":";
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_item(logic [ByteW-1:0] b, logic f);
    stim_q.push_back('{b, f});
  endfunction

  // Build one message: well-formed chunks, an ending; either may then be broken
  function automatic void build_message(int lim);
    int               nchunks, sz, roll, pos;
    logic [SizeW-1:0] big;
    msg_q.delete();
    roll    = $urandom_range(0, 99);
    nchunks = $urandom_range(0, 3);
    repeat (nchunks) begin
      if (lim == 1 || $urandom_range(0, 9) != 0) sz = $urandom_range(1, 15);
      else sz = $urandom_range(16, 120);
      push_size_line(sz, $urandom_range(min_digits(sz), lim));
      repeat (sz) msg_q.push_back(ByteW'($urandom_range(0, 255)));
      msg_q.push_back(ChCr);
      msg_q.push_back(ChLf);
    end
    if (roll < 6) begin
      // huge chunk, abandoned after a few bytes by the next message
      big = {$urandom};
      if (lim < SizeDigitsLimit) big = big & ((SizeW'(1) << (NibbleW * lim)) - 1);
      push_size_line(big, lim);
      repeat ($urandom_range(1, 12)) msg_q.push_back(ByteW'($urandom_range(0, 255)));
    end else if (roll < 10) begin
      // one digit over the limit
      repeat (lim + 1) msg_q.push_back(hex_char($urandom_range(0, 15)));
      msg_q.push_back(ChCr);
    end else if (roll < 13) begin
      msg_q.push_back(ChCr);
      msg_q.push_back(ChLf);
    end else begin
      push_size_line('0, $urandom_range(1, lim));
      msg_q.push_back(ChCr);
      msg_q.push_back(ChLf);
    end
    if (roll >= 13 && $urandom_range(0, 4) == 0) begin
      pos        = $urandom_range(0, msg_q.size() - 1);
      msg_q[pos] = noise_byte();
    end
    if ($urandom_range(0, 9) == 0 && msg_q.size() > 1) begin
      pos = $urandom_range(1, msg_q.size() - 1);
      while (msg_q.size() > pos) void'(msg_q.pop_back());
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) msg_q.push_back(noise_byte());
    end
    foreach (msg_q[i]) push_item(msg_q[i], i == 0);
  endfunction

  // Present one word and hold it until taken
  task automatic send_byte(input logic [ByteW-1:0] b, input logic f);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, f);
  endtask

  task automatic pause(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Send the queued words in bursts with random gaps
  task automatic play_stimulus();
    in_item_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      send_byte(it.b, it.f);
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 30);
        if ($urandom_range(0, 19) == 0) wait_drained();
        else if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
      end
    end
  endtask

  task automatic write_limit(input logic [CfgW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_limit(v);
    limits_run++;
  endtask

  initial begin
    logic [CfgW-1:0] limit_list[13];
    limit_list = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd9, 4'd3, 4'd7, 4'd2, 4'd5, 4'd12, 4'd6,
                   4'd4, 4'd10};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: complete message with extreme body byte, then halted byte
    push_item("1", 1'b1); push_item(ChCr, 1'b0); push_item(ChLf, 1'b0);
    push_item(8'hFF, 1'b0); push_item(ChCr, 1'b0); push_item(ChLf, 1'b0);
    push_item("0", 1'b0); push_item(ChCr, 1'b0); push_item(ChLf, 1'b0);
    push_item(ChCr, 1'b0); push_item(ChLf, 1'b0); push_item(8'h00, 1'b0);
    // empty size line, bad size character, missing LF
    push_item(ChCr, 1'b1);
    push_item("G", 1'b1);
    push_item("a", 1'b1); push_item("F", 1'b0); push_item(ChCr, 1'b0); push_item("x", 1'b0);
    // too many digits at the reset limit of five
    push_item("1", 1'b1);
    foreach (limit_list[i]) if (i < 5) push_item(hex_char(i + 2), 1'b0);
    play_stimulus();
    wait_drained();

    // Random messages under each digit limit
    foreach (limit_list[i]) begin
      write_limit(limit_list[i]);
      while (stim_q.size() < 130) build_message(clamp_limit(limit_list[i]));
      play_stimulus();
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Decoded %0d bytes under %0d digit limits: %0d body, %0d complete, %0d error.",
             sb.bytes_seen, limits_run + 1, sb.body_seen, sb.done_seen, sb.err_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
